// ===== src/frs_pkg.sv =====
// Shared types and constants for the FIFO-replacement ID store.
package frs_pkg;

    localparam int ID_W  = 32;  // ID width on the stream ports
    localparam int POS_W = 4;   // read position width
    localparam int OCC_W = 5;   // occupancy field width
    localparam int CAP_W = 5;   // capacity register width

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic shift_en;  // load the neighbor's ID this cycle
        logic lookup;    // current beat is an access, compare is live
    } cell_ctrl_t;

endpackage

// ===== src/frs_cell.sv =====
// One entry of the ID chain: holds an ID, compares it, shifts toward the old end.
module frs_cell
    import frs_pkg::*;
#(
    parameter int ID_WIDTH = 32,
    parameter int SEL_W    = 5,
    parameter int INDEX    = 0
)(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [ID_WIDTH-1:0] prev_id,   // from newer neighbor, or new ID at cell 0
    input  logic [SEL_W-1:0]    count,
    input  logic [SEL_W-1:0]    sel,
    input  logic [ID_WIDTH-1:0] lookup_id,
    output logic [ID_WIDTH-1:0] id_out,    // to older neighbor
    output logic                match,
    output logic [ID_WIDTH-1:0] sel_id     // own ID when selected, else zero
);

    localparam logic [SEL_W-1:0] MY_INDEX = SEL_W'(INDEX);

    logic [ID_WIDTH-1:0] id_reg;
    logic                held;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            id_reg <= prev_id;
        end
    end

    // position counts from the newest end, so entry is live below count
    assign held   = MY_INDEX < count;
    assign id_out = id_reg;
    assign match  = ctrl.lookup && held && (id_reg == lookup_id);
    assign sel_id = (sel == MY_INDEX) ? id_reg : '0;

endmodule

// ===== src/fifo_replacement_id_store_core.sv =====
// Top level of the FIFO-replacement ID store: cell chain, control and output register.
// An accepted input beat's result is registered in the output register.
// Throughput: one item per cycle unless stalled; each is a single parallel cell compare pass.
// The input is held off only while a result waits in the output register and m_tready is low.
// Reset (rst_n low, asynchronous): store empty, capacity 16.
// Entry IDs carry no reset; slots past the occupancy are never compared or read.
module fifo_replacement_id_store_core
    import frs_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: capacity register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // capacity
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // item_id[31:0], position[35:32], zero pad[39:36]
    input  logic [0:0]  s_tuser,      // opcode[0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata       // hit[0], evicted_valid[1], evicted_id[33:2],
                                      // occupancy[38:34], read_valid[39], read_id[71:40]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic [71:0]      out_data_reg;

    // ---------------------------------------------------------------
    // Beat decode
    // ---------------------------------------------------------------
    logic [ID_W-1:0]     in_id;
    logic [POS_W-1:0]    in_pos;
    logic                access;
    logic                accept;
    logic [ID_WIDTH-1:0] lookup_id;

    assign in_id     = s_tdata[31:0];
    assign in_pos    = s_tdata[35:32];
    assign lookup_id = ID_WIDTH'(in_id);   // IDs kept modulo 2^ID_WIDTH

    always_comb
    begin
        unique case (s_tuser[0])
            OP_ACCESS: access = 1'b1;
            OP_READ:   access = 1'b0;
        endcase
    end

    // output register parts the two sides; a waiting result only stalls if not taken
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Effective capacity: zero means one, above the built depth saturates
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] eff_cap;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = ONE_C;
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            eff_cap = DEPTH_C;
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // ---------------------------------------------------------------
    // Cell chain. Cell 0 is the newest entry; a miss shifts every cell one
    // step toward the old end and loads the new ID into cell 0. The oldest
    // held entry sits at cell count-1, so a read of position p is cell p.
    // ---------------------------------------------------------------
    cell_ctrl_t          ctrl;
    logic [SEL_W-1:0]    count_sel;
    logic [SEL_W-1:0]    sel;
    logic [ID_WIDTH-1:0] chain_id [DEPTH+1];
    logic [DEPTH-1:0]    match_vec;
    logic [ID_WIDTH-1:0] sel_vec  [DEPTH];

    logic hit, evict;

    assign count_sel = SEL_W'(count_reg);
    // one shared select: oldest entry on an access, requested position on a read
    // (count zero wraps past every cell index, and no eviction happens then)
    assign sel = access ? SEL_W'(count_reg - ONE_C) : SEL_W'(in_pos);

    assign chain_id[0]   = lookup_id;
    assign ctrl.lookup   = access;
    assign ctrl.shift_en = accept && access && !hit;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        frs_cell #(
            .ID_WIDTH (ID_WIDTH),
            .SEL_W    (SEL_W),
            .INDEX    (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_id   (chain_id[i]),
            .count     (count_sel),
            .sel       (sel),
            .lookup_id (lookup_id),
            .id_out    (chain_id[i+1]),
            .match     (match_vec[i]),
            .sel_id    (sel_vec[i])
        );
    end

    // select outputs are one-hot or zero, so an OR gathers the chosen ID
    logic [ID_WIDTH-1:0] sel_data;

    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_data = sel_data | sel_vec[i];
        end
    end

    assign hit   = |match_vec;
    assign evict = access && !hit && (count_reg >= eff_cap);

    // occupancy grows on a miss with room; an eviction keeps it level
    always_comb
    begin
        count_next = count_reg;
        if (access && !hit && !evict)
        begin
            count_next = count_reg + ONE_C;
        end
    end

    // ---------------------------------------------------------------
    // Result fields
    // ---------------------------------------------------------------
    logic            read_valid;
    logic [ID_W-1:0] evicted_id;
    logic [ID_W-1:0] read_id;
    logic [OCC_W-1:0] occupancy;

    assign read_valid = !access && (SEL_W'(in_pos) < count_sel);
    assign evicted_id = evict      ? ID_W'(sel_data) : '0;
    assign read_id    = read_valid ? ID_W'(sel_data) : '0;
    assign occupancy  = OCC_W'(count_next);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(16);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {read_id, read_valid, occupancy, evicted_id,
                             evict, access && hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/frs_checker.sv =====
// Port-level checker for the FIFO-replacement ID store, bound to the top level.
module frs_checker
    import frs_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic            r_hit, r_ev, r_rd;
    logic [ID_W-1:0] r_ev_id, r_rd_id;
    logic [OCC_W-1:0] r_occ;

    assign r_hit   = m_tdata[0];
    assign r_ev    = m_tdata[1];
    assign r_ev_id = m_tdata[33:2];
    assign r_occ   = m_tdata[38:34];
    assign r_rd    = m_tdata[39];
    assign r_rd_id = m_tdata[71:40];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every accepted item yields a result in the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // a hit never evicts, and a read never reports hit or eviction
    a_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(r_hit && r_ev) && !(r_rd && (r_hit || r_ev)))
        else $error("conflicting result flags");

    // ID fields are zero whenever their flag is clear
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_ev || r_ev_id == '0) && (r_rd || r_rd_id == '0))
        else $error("ID field nonzero without its flag");

    // occupancy never exceeds the built depth
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 32) |-> 32'(r_occ) <= DEPTH)
        else $error("occupancy above depth");

endmodule

bind fifo_replacement_id_store_core frs_checker #(.DEPTH(DEPTH)) u_frs_checker (.*);
